FILE: rtl/mbrrc_pkg.sv
// Shared types, constants and the CRC byte update for the function-3 response checker.
`timescale 1ns / 1ps

package mbrrc_pkg;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [7:0]  FUNC_READ      = 8'h03;
   localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
   localparam logic [8:0]  COUNT_LIMIT    = 9'd511;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_COUNT  = 3'd1,
      STATUS_BAD_LENGTH = 3'd2,
      STATUS_BAD_HEADER = 3'd3,
      STATUS_BAD_CRC    = 3'd4
   } status_type;

   // one byte through the reflected CRC-16, LSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/mbrrc_req_if.sv
// Request channel: one received frame byte with its frame-end mark and expectations.
`timescale 1ns / 1ps

interface mbrrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;
   logic [7:0] expect_slave;
   logic [4:0] expect_count;

   modport source (output valid, output rx_byte, output frame_end, output expect_slave,
                   output expect_count, input ready);
   modport sink   (input valid, input rx_byte, input frame_end, input expect_slave,
                   input expect_count, output ready);
endinterface

FILE: rtl/mbrrc_rsp_if.sv
// Response channel: one checked register value or one error status.
`timescale 1ns / 1ps

interface mbrrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] reg_value;
   logic [3:0]  reg_index;
   logic        last;

   modport source (output valid, output status, output reg_value, output reg_index,
                   output last, input ready);
   modport sink   (input valid, input status, input reg_value, input reg_index,
                   input last, output ready);
endinterface

FILE: rtl/mbrrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mbrrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/modbus_read_response_checker.sv
// Top level: Modbus RTU function-3 response checker with a RAM-held value store.
//
//   channel   dir  handshake        contents
//   req_ch    in   valid/ready      rx_byte, frame_end, expect_slave, expect_count
//   rsp_ch    out  valid/ready      status, reg_value, reg_index, last
//
// A byte is taken only while the checker is idle. A byte with frame_end leads to a check
// state; a good frame then drains each value by a RAM read, then a load of the
// output register. reset clears control and frame state; the value store is not cleared.
// A stalled rsp_ch holds the output register and pauses the drain; bytes are taken again
// once the last result of the frame sits in the output register.
`timescale 1ns / 1ps

module modbus_read_response_checker #(
   parameter int MAX_REGISTERS = 16
) (
   input  logic         clock,
   input  logic         reset,
   mbrrc_req_if.sink    req_ch,
   mbrrc_rsp_if.source  rsp_ch
);

   localparam int AW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;
   localparam logic [7:0] MAX_REG8 = 8'(MAX_REGISTERS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_READ  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   logic        in_frame_ff, in_frame_in;
   logic [8:0]  byte_count_ff, byte_count_in;
   logic [15:0] crc_ff, crc_in;
   logic        header_bad_ff, header_bad_in;
   logic [7:0]  slave_ff, slave_in;
   logic [4:0]  count_ff, count_in;
   logic [7:0]  high_hold_ff, high_hold_in;
   logic [4:0]  idx_ff, idx_in;

   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic [15:0] out_value_ff, out_value_in;
   logic [3:0]  out_index_ff, out_index_in;
   logic        out_last_ff, out_last_in;

   logic        accept, out_free;
   logic [7:0]  cur_slave;
   logic [4:0]  cur_count;
   logic [15:0] cur_crc;
   logic [8:0]  pos;
   logic        cur_hdr_bad;
   logic [8:0]  data_off;
   logic [7:0]  data_idx;
   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]  rd_idx8;
   logic        rd_en;
   logic [15:0] rd_data;
   mbrrc_pkg::status_type check_status;
   logic [5:0]  idx_plus;
   logic        is_last;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   // first byte of a frame sees freshly opened frame state
   assign cur_slave   = in_frame_ff ? slave_ff      : req_ch.expect_slave;
   assign cur_count   = in_frame_ff ? count_ff      : req_ch.expect_count;
   assign cur_crc     = in_frame_ff ? crc_ff        : mbrrc_pkg::CRC_INIT;
   assign pos         = in_frame_ff ? byte_count_ff : 9'd0;
   assign cur_hdr_bad = in_frame_ff && header_bad_ff;

   assign data_off = pos - 9'd4;
   assign data_idx = data_off[8:1];
   assign wr_en    = accept && (pos >= 9'd4) && !pos[0]
                     && (data_idx < {3'b000, cur_count}) && (data_idx < MAX_REG8);
   assign wr_addr  = data_idx[AW-1:0];

   assign rd_idx8 = {3'b000, idx_ff};
   assign rd_en   = (state_ff == ST_READ);

   assign idx_plus = {1'b0, idx_ff} + 6'd1;
   assign is_last  = (idx_plus == {1'b0, count_ff});

   always_comb begin
      if (count_ff == 5'd0 || {3'b000, count_ff} > MAX_REG8) begin
         check_status = mbrrc_pkg::STATUS_BAD_COUNT;
      end else if (byte_count_ff != ({3'b000, count_ff, 1'b0} + mbrrc_pkg::FRAME_OVERHEAD)) begin
         check_status = mbrrc_pkg::STATUS_BAD_LENGTH;
      end else if (header_bad_ff) begin
         check_status = mbrrc_pkg::STATUS_BAD_HEADER;
      end else if (crc_ff != 16'h0000) begin
         check_status = mbrrc_pkg::STATUS_BAD_CRC;
      end else begin
         check_status = mbrrc_pkg::STATUS_OK;
      end
   end

   always_comb begin
      state_in      = state_ff;
      in_frame_in   = in_frame_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      header_bad_in = header_bad_ff;
      slave_in      = slave_ff;
      count_in      = count_ff;
      high_hold_in  = high_hold_ff;
      idx_in        = idx_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      out_index_in  = out_index_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slave_in      = cur_slave;
               count_in      = cur_count;
               crc_in        = mbrrc_pkg::crc_feed(cur_crc, req_ch.rx_byte);
               byte_count_in = (pos < mbrrc_pkg::COUNT_LIMIT) ? pos + 9'd1 : pos;
               header_bad_in = cur_hdr_bad;
               if (pos == 9'd0) begin
                  if (req_ch.rx_byte != cur_slave) header_bad_in = 1'b1;
               end else if (pos == 9'd1) begin
                  if (req_ch.rx_byte != mbrrc_pkg::FUNC_READ) header_bad_in = 1'b1;
               end else if (pos == 9'd2) begin
                  if (req_ch.rx_byte != {2'b00, cur_count, 1'b0}) header_bad_in = 1'b1;
               end else if (pos[0]) begin
                  high_hold_in = req_ch.rx_byte;
               end
               in_frame_in = !req_ch.frame_end;
               if (req_ch.frame_end) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            idx_in = 5'd0;
            if (check_status != mbrrc_pkg::STATUS_OK) begin
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_status_in = check_status;
                  out_value_in  = 16'h0000;
                  out_index_in  = 4'd0;
                  out_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = mbrrc_pkg::STATUS_OK;
               out_value_in  = rd_data;
               out_index_in  = idx_ff[3:0];
               out_last_in   = is_last;
               idx_in        = idx_plus[4:0];
               state_in      = is_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         in_frame_ff   <= 1'b0;
         byte_count_ff <= 9'd0;
         crc_ff        <= mbrrc_pkg::CRC_INIT;
         header_bad_ff <= 1'b0;
         slave_ff      <= 8'd0;
         count_ff      <= 5'd0;
         high_hold_ff  <= 8'd0;
         idx_ff        <= 5'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         in_frame_ff   <= in_frame_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         header_bad_ff <= header_bad_in;
         slave_ff      <= slave_in;
         count_ff      <= count_in;
         high_hold_ff  <= high_hold_in;
         idx_ff        <= idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
      out_index_ff  <= out_index_in;
      out_last_ff   <= out_last_in;
   end

   mbrrc_ram #(
      .WIDTH (16),
      .DEPTH (MAX_REGISTERS),
      .AW    (AW)
   ) u_value_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({high_hold_ff, req_ch.rx_byte}),
      .rd_en   (rd_en),
      .rd_addr (rd_idx8[AW-1:0]),
      .rd_data (rd_data)
   );

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.status    = out_status_ff;
   assign rsp_ch.reg_value = out_value_ff;
   assign rsp_ch.reg_index = out_index_ff;
   assign rsp_ch.last      = out_last_ff;

endmodule
